// ===== rtl/cbc_pkg.sv =====
package cbc_pkg;

   localparam int RamDepthDefault   = 131072;
   localparam int RomAddrBitsDefault = 23;

   localparam logic [2:0] KIND_PLAIN = 3'd0;
   localparam logic [2:0] KIND_MBC1  = 3'd1;
   localparam logic [2:0] KIND_MBC2  = 3'd2;
   localparam logic [2:0] KIND_MBC3  = 3'd3;
   localparam logic [2:0] KIND_MBC5  = 3'd4;

   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   localparam logic [1:0] CSR_KIND      = 2'd0;
   localparam logic [1:0] CSR_HAS_CLOCK = 2'd1;
   localparam logic [1:0] CSR_ROM_BYTES = 2'd2;
   localparam logic [1:0] CSR_RAM_BYTES = 2'd3;

   localparam logic [7:0] CLK_SEC  = 8'h08;
   localparam logic [7:0] CLK_MIN  = 8'h09;
   localparam logic [7:0] CLK_HOUR = 8'h0A;
   localparam logic [7:0] CLK_DAYL = 8'h0B;
   localparam logic [7:0] CLK_DAYH = 8'h0C;

   typedef struct packed {
      logic [5:0] sec;
      logic [5:0] min;
      logic [4:0] hour;
      logic [8:0] day;
      logic       halt;
      logic       carry;
   } rtc_type;

   // Mask of the largest power of two not above v (all ones below that bit).
   function automatic logic [17:0] ram_mask(input logic [17:0] v);
      logic [17:0] m;
      begin
         m = v;
         m = m | (m >> 1);
         m = m | (m >> 2);
         m = m | (m >> 4);
         m = m | (m >> 8);
         m = m | (m >> 16);
         return m >> 1;
      end
   endfunction

   // v mod 60 through a reciprocal multiply; quotient is at most 4.
   function automatic logic [5:0] mod60(input logic [7:0] v);
      logic [18:0] p;
      logic [2:0]  q;
      logic [7:0]  r;
      begin
         p = 19'(v) * 19'd1093;
         q = p[18:16];
         r = v - (8'(q) * 8'd60);
         return r[5:0];
      end
   endfunction

   // v mod 24; quotient is at most 10.
   function automatic logic [4:0] mod24(input logic [7:0] v);
      logic [15:0] p;
      logic [3:0]  q;
      logic [7:0]  r;
      begin
         p = 16'(v) * 16'd171;
         q = p[15:12];
         r = v - (8'(q) * 8'd24);
         return r[4:0];
      end
   endfunction

endpackage

// ===== rtl/cbc_ram.sv =====
module cbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

// ===== rtl/cartridge_bank_controller_with_clock.sv =====
// Channel   Dir  Handshake             Payload
// req       in   req_tvalid/req_tready tuser: req_type; tdata: bus_address, write_data
// rsp       out  rsp_tvalid/rsp_tready tuser: rom_fetch; tdata: read_data, rom_fetch_addr
// csr       in   csr_we                csr_index, csr_wdata
//
// One request per cycle while req_tready is high; each result appears in the
// cycle after its request is accepted, and the RAM read register is the output stage.
// Reset is synchronous; after it, the RAM is cleared word by word while
// req_tready stays low. A stalled result holds and blocks new requests.
module cartridge_bank_controller_with_clock #(
   parameter int RAM_DEPTH     = cbc_pkg::RamDepthDefault,
   parameter int ROM_ADDR_BITS = cbc_pkg::RomAddrBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   input  logic [23:0] req_tdata,   // [15:0] bus_address, [23:16] write_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // [0] rom_fetch
   output logic [31:0] rsp_tdata,   // [7:0] read_data, [30:8] rom_fetch_addr
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import cbc_pkg::*;

   localparam int AW = $clog2(RAM_DEPTH);

   logic [2:0]  kind_ff;
   logic        has_clock_ff;
   logic [23:0] rom_bytes_ff;
   logic [17:0] ram_bytes_ff;

   logic [7:0]  bank_low_ff, bank_low_in;
   logic        bank_high_ff, bank_high_in;
   logic [3:0]  ram_bank_ff, ram_bank_in;
   logic        mode_ff, mode_in;
   logic        gate_ff, gate_in;
   logic [7:0]  sel_ff, sel_in;
   logic [7:0]  latch_ff, latch_in;
   rtc_type     live_ff, live_in, latched_ff, latched_in;

   logic          clearing_ff;
   logic [AW-1:0] clr_cnt_ff;

   logic          s1_v_ff, s1_ram_ff, s1_nib_ff, s1_fetch_ff;
   logic [7:0]    s1_data_ff;
   logic [22:0]   s1_faddr_ff;

   logic        accept, is_rd, is_wr, in_rom, in_win;
   logic [15:0] a;
   logic [7:0]  v;
   logic [2:0]  kind;
   logic [8:0]  bank;
   logic [22:0] rom_off;
   logic        rom_ok;
   logic        gate_open, clk_sel, ram_ok;
   logic [17:0] ram_clamp, mask;
   logic [3:0]  rbank;
   logic [17:0] ridx;
   logic [7:0]  clk_rd;
   logic        ram_en, ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]  ram_wdata, ram_rdata;
   logic [7:0]  c_data;
   logic        c_ram, c_fetch;

   assign a      = req_tdata[15:0];
   assign v      = req_tdata[23:16];
   assign accept = req_tvalid && req_tready;
   assign is_rd  = req_tuser == REQ_READ;
   assign is_wr  = req_tuser == REQ_WRITE;
   assign in_rom = !a[15];
   assign in_win = a[15:13] == 3'b101;
   assign kind   = (kind_ff > KIND_MBC5) ? KIND_PLAIN : kind_ff;

   assign req_tready = !clearing_ff && (!s1_v_ff || rsp_tready);

   always_comb begin
      case (kind)
         KIND_MBC1: bank = a[14] ? {2'b0, ram_bank_ff[1:0], bank_low_ff[4:0]}
                                 : (mode_ff ? {2'b0, ram_bank_ff[1:0], 5'b0} : 9'd0);
         KIND_MBC2: bank = a[14] ? {5'b0, bank_low_ff[3:0]} : 9'd0;
         KIND_MBC3: bank = a[14] ? {2'b0, bank_low_ff[6:0]} : 9'd0;
         KIND_MBC5: bank = a[14] ? {bank_high_ff, bank_low_ff} : 9'd0;
         default:   bank = a[14] ? 9'd1 : 9'd0;
      endcase
   end

   assign rom_off = {bank, a[13:0]};
   assign rom_ok  = ({1'b0, rom_off} < rom_bytes_ff) &&
                    ((rom_off >> ROM_ADDR_BITS) == 23'd0);

   assign gate_open = (kind == KIND_PLAIN) || gate_ff;
   assign clk_sel   = (kind == KIND_MBC3) && has_clock_ff &&
                      (sel_ff >= CLK_SEC) && (sel_ff <= CLK_DAYH);
   assign ram_clamp = (ram_bytes_ff > 18'(RAM_DEPTH)) ? 18'(RAM_DEPTH) : ram_bytes_ff;
   assign mask      = ram_mask(ram_clamp);
   assign ram_ok    = gate_open && !clk_sel && (ram_clamp != 18'd0) &&
                      !((kind == KIND_MBC3) && (sel_ff > 8'h03));
   assign rbank     = ((kind == KIND_MBC2) || ((kind == KIND_MBC1) && !mode_ff))
                      ? 4'd0 : ram_bank_ff;
   assign ridx      = {1'b0, rbank, a[12:0]} & mask;

   always_comb begin
      case (sel_ff)
         CLK_SEC:  clk_rd = {2'b0, latched_ff.sec};
         CLK_MIN:  clk_rd = {2'b0, latched_ff.min};
         CLK_HOUR: clk_rd = {3'b0, latched_ff.hour};
         CLK_DAYL: clk_rd = latched_ff.day[7:0];
         default:  clk_rd = {latched_ff.carry, latched_ff.halt, 5'b0, latched_ff.day[8]};
      endcase
   end

   // Result fields that do not come from the RAM
   always_comb begin
      c_data  = 8'd0;
      c_ram   = 1'b0;
      c_fetch = 1'b0;
      if (is_rd) begin
         if (in_rom) begin
            c_fetch = rom_ok;
            c_data  = rom_ok ? 8'd0 : 8'hFF;
         end else if (in_win) begin
            if (!gate_open)   c_data = 8'hFF;
            else if (clk_sel) c_data = clk_rd;
            else if (ram_ok)  c_ram  = 1'b1;
            else              c_data = 8'hFF;
         end else begin
            c_data = 8'hFF;
         end
      end
   end

   assign ram_en    = clearing_ff || (accept && in_win && ram_ok && (is_rd || is_wr));
   assign ram_we    = clearing_ff || is_wr;
   assign ram_addr  = clearing_ff ? clr_cnt_ff : ridx[AW-1:0];
   assign ram_wdata = clearing_ff ? 8'd0 : ((kind == KIND_MBC2) ? {4'd0, v[3:0]} : v);

   cbc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Bank registers, clock writes, latch and ticks
   always_comb begin
      bank_low_in  = bank_low_ff;
      bank_high_in = bank_high_ff;
      ram_bank_in  = ram_bank_ff;
      mode_in      = mode_ff;
      gate_in      = gate_ff;
      sel_in       = sel_ff;
      latch_in     = latch_ff;
      live_in      = live_ff;
      latched_in   = latched_ff;
      if (accept && is_wr && in_rom) begin
         case (kind)
            KIND_MBC1: begin
               case (a[14:13])
                  2'd0:    gate_in = v[3:0] == 4'hA;
                  2'd1:    bank_low_in = (v[4:0] == 5'd0) ? 8'd1 : {3'd0, v[4:0]};
                  2'd2:    ram_bank_in = {2'd0, v[1:0]};
                  default: mode_in = v[0];
               endcase
            end
            KIND_MBC2: begin
               if (!a[14]) begin
                  if (a[8]) bank_low_in = (v[3:0] == 4'd0) ? 8'd1 : {4'd0, v[3:0]};
                  else      gate_in = v[3:0] == 4'hA;
               end
            end
            KIND_MBC3: begin
               case (a[14:13])
                  2'd0:    gate_in = v[3:0] == 4'hA;
                  2'd1:    bank_low_in = (v[6:0] == 7'd0) ? 8'd1 : {1'b0, v[6:0]};
                  2'd2: begin
                     sel_in = v;
                     if (v <= 8'h03) ram_bank_in = v[3:0];
                  end
                  default: begin
                     if (latch_ff == 8'd0 && v == 8'd1) latched_in = live_ff;
                     latch_in = v;
                  end
               endcase
            end
            KIND_MBC5: begin
               case (a[14:12])
                  3'd0, 3'd1: gate_in = v[3:0] == 4'hA;
                  3'd2:       bank_low_in = v;
                  3'd3:       bank_high_in = v[0];
                  3'd4, 3'd5: ram_bank_in = v[3:0];
                  default:    ;
               endcase
            end
            default: ;
         endcase
      end
      if (accept && is_wr && in_win && gate_open && clk_sel) begin
         case (sel_ff)
            CLK_SEC:  live_in.sec  = mod60(v);
            CLK_MIN:  live_in.min  = mod60(v);
            CLK_HOUR: live_in.hour = mod24(v);
            CLK_DAYL: live_in.day  = {live_ff.day[8], v};
            default: begin
               live_in.day   = {v[0], live_ff.day[7:0]};
               live_in.halt  = v[6];
               live_in.carry = v[7];
            end
         endcase
      end
      if (accept && req_tuser == REQ_TICK && kind == KIND_MBC3 && has_clock_ff &&
          !live_ff.halt) begin
         if (live_ff.sec < 6'd59) begin
            live_in.sec = live_ff.sec + 6'd1;
         end else begin
            live_in.sec = 6'd0;
            if (live_ff.min < 6'd59) begin
               live_in.min = live_ff.min + 6'd1;
            end else begin
               live_in.min = 6'd0;
               if (live_ff.hour < 5'd23) begin
                  live_in.hour = live_ff.hour + 5'd1;
               end else begin
                  live_in.hour = 5'd0;
                  live_in.day  = live_ff.day + 9'd1;
                  if (live_ff.day == 9'h1FF) live_in.carry = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_PLAIN;
         has_clock_ff <= 1'b0;
         rom_bytes_ff <= 24'd32768;
         ram_bytes_ff <= 18'd0;
         bank_low_ff  <= 8'd1;
         bank_high_ff <= 1'b0;
         ram_bank_ff  <= 4'd0;
         mode_ff      <= 1'b0;
         gate_ff      <= 1'b0;
         sel_ff       <= 8'd0;
         latch_ff     <= 8'hFF;
         live_ff      <= '0;
         latched_ff   <= '0;
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_v_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KIND:      kind_ff      <= csr_wdata[2:0];
               CSR_HAS_CLOCK: has_clock_ff <= csr_wdata[0];
               CSR_ROM_BYTES: rom_bytes_ff <= csr_wdata;
               CSR_RAM_BYTES: ram_bytes_ff <= csr_wdata[17:0];
               default:       ;
            endcase
         end
         bank_low_ff  <= bank_low_in;
         bank_high_ff <= bank_high_in;
         ram_bank_ff  <= ram_bank_in;
         mode_ff      <= mode_in;
         gate_ff      <= gate_in;
         sel_ff       <= sel_in;
         latch_ff     <= latch_in;
         live_ff      <= live_in;
         latched_ff   <= latched_in;
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(RAM_DEPTH - 1)) clearing_ff <= 1'b0;
         end
         if (accept)          s1_v_ff <= 1'b1;
         else if (rsp_tready) s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ram_ff   <= c_ram;
         s1_nib_ff   <= kind == KIND_MBC2;
         s1_data_ff  <= c_data;
         s1_fetch_ff <= c_fetch;
         s1_faddr_ff <= c_fetch ? rom_off : 23'd0;
      end
   end

   assign rsp_tvalid = s1_v_ff;
   assign rsp_tuser  = s1_fetch_ff;
   assign rsp_tdata  = {1'b0, s1_faddr_ff,
                        s1_ram_ff ? (s1_nib_ff ? {4'hF, ram_rdata[3:0]} : ram_rdata)
                                  : s1_data_ff};

   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_tready)
      else $error("request taken during RAM clear");

   a_fetch_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("ROM fetch carries read data");

   a_fetch_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> ({1'b0, rsp_tdata[30:8]} < rom_bytes_ff))
      else $error("ROM fetch past ROM size");

   a_tick_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == REQ_TICK) |=> (rsp_tdata == 32'd0 && !rsp_tuser))
      else $error("tick gave nonzero result");

endmodule

// ===== tb/cartridge_bank_controller_with_clock_test.sv =====
`timescale 1ns / 100ps

module cartridge_bank_controller_with_clock_test;
   import cbc_pkg::*;

   localparam logic [1:0] REQ_NONE = 2'd3;   // undefined request type
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASES = 9;

   class bank_scoreboard;
      localparam int RAM_DEPTH_TB = 131072;

      typedef struct {
         int unsigned sec, min, hour, day;
         bit halt, carry;
      } clock_regs_type;

      typedef struct {
         logic [7:0]  data;
         logic        fetch;
         logic [22:0] addr;
      } bus_result_type;

      int unsigned kind, has_clk, rom_size, ram_cfg;
      int unsigned bank_lo, bank_hi, ram_bank, mode, gate, sel, latch_prev;
      clock_regs_type live, held;
      logic [7:0] ram [RAM_DEPTH_TB];
      bus_result_type expected_q[$];
      int errors, checked, fetches, clock_reads;

      function void clear();
         kind = 0; has_clk = 0; rom_size = 32768; ram_cfg = 0;
         bank_lo = 1; bank_hi = 0; ram_bank = 0; mode = 0; gate = 0; sel = 0;
         latch_prev = 8'hFF;
         live = '{0, 0, 0, 0, 0, 0};
         held = live;
         foreach (ram[i]) ram[i] = 8'h00;
      endfunction

      function void set_reg(logic [1:0] idx, int unsigned v);
         case (idx)
            CSR_KIND:      kind = v & 7;
            CSR_HAS_CLOCK: has_clk = v & 1;
            CSR_ROM_BYTES: rom_size = v & 24'hFFFFFF;
            default:       ram_cfg = v & 18'h3FFFF;
         endcase
      endfunction

      function int unsigned kind_eff();
         return kind > 4 ? 0 : kind;
      endfunction

      function int unsigned ram_span();
         int unsigned n, p;
         n = ram_cfg > RAM_DEPTH_TB ? RAM_DEPTH_TB : ram_cfg;
         p = 1;
         if (n == 0) return 0;
         while (p * 2 <= n) p *= 2;
         return p;
      endfunction

      function int unsigned rom_bank(int unsigned a);
         bit lo;
         lo = a < 16'h4000;
         case (kind_eff())
            KIND_MBC1: begin
               if (lo) return mode ? (ram_bank & 3) << 5 : 0;
               return ((ram_bank & 3) << 5) | (bank_lo & 8'h1F);
            end
            KIND_MBC2: return lo ? 0 : bank_lo & 8'h0F;
            KIND_MBC3: return lo ? 0 : bank_lo & 8'h7F;
            KIND_MBC5: return lo ? 0 : ((bank_hi & 1) << 8) | (bank_lo & 8'hFF);
            default:   return lo ? 0 : 1;
         endcase
      endfunction

      function bit on_clock();
         return kind_eff() == KIND_MBC3 && has_clk && sel >= CLK_SEC && sel <= CLK_DAYH;
      endfunction

      function int unsigned rtc_read();
         case (sel)
            CLK_SEC:  return held.sec;
            CLK_MIN:  return held.min;
            CLK_HOUR: return held.hour;
            CLK_DAYL: return held.day & 8'hFF;
            default:  return ((held.day >> 8) & 1) | (held.halt ? 8'h40 : 0)
                             | (held.carry ? 8'h80 : 0);
         endcase
      endfunction

      function void rtc_write(int unsigned v);
         case (sel)
            CLK_SEC:  live.sec = v % 60;
            CLK_MIN:  live.min = v % 60;
            CLK_HOUR: live.hour = v % 24;
            CLK_DAYL: live.day = (live.day & 9'h100) | v;
            default: begin
               live.day = (live.day & 8'hFF) | ((v & 1) << 8);
               live.halt = (v & 8'h40) != 0;
               live.carry = (v & 8'h80) != 0;
            end
         endcase
      endfunction

      function void rtc_advance();
         if (kind_eff() != KIND_MBC3 || !has_clk || live.halt) return;
         if (++live.sec < 60) return;
         live.sec = 0;
         if (++live.min < 60) return;
         live.min = 0;
         if (++live.hour < 24) return;
         live.hour = 0;
         if (++live.day > 9'h1FF) begin
            live.day = 0;
            live.carry = 1;
         end
      endfunction

      function void bank_write(int unsigned a, int unsigned v);
         case (kind_eff())
            KIND_MBC1: begin
               if (a < 16'h2000) gate = (v & 4'hF) == 4'hA;
               else if (a < 16'h4000) bank_lo = (v & 8'h1F) == 0 ? 1 : v & 8'h1F;
               else if (a < 16'h6000) ram_bank = v & 3;
               else mode = v & 1;
            end
            KIND_MBC2: begin
               if (a < 16'h4000) begin
                  if (a & 16'h0100) bank_lo = (v & 4'hF) == 0 ? 1 : v & 4'hF;
                  else gate = (v & 4'hF) == 4'hA;
               end
            end
            KIND_MBC3: begin
               if (a < 16'h2000) gate = (v & 4'hF) == 4'hA;
               else if (a < 16'h4000) bank_lo = (v & 8'h7F) == 0 ? 1 : v & 8'h7F;
               else if (a < 16'h6000) begin
                  sel = v;
                  if (v <= 3) ram_bank = v;
               end else begin
                  if (latch_prev == 0 && v == 1) held = live;
                  latch_prev = v;
               end
            end
            KIND_MBC5: begin
               if (a < 16'h2000) gate = (v & 4'hF) == 4'hA;
               else if (a < 16'h3000) bank_lo = v;
               else if (a < 16'h4000) bank_hi = v & 1;
               else if (a < 16'h6000) ram_bank = v & 4'hF;
            end
            default: ;
         endcase
      endfunction

      function int unsigned window(int unsigned a, int unsigned v, bit wr);
         int unsigned span, idx, bank;
         if (!(kind_eff() == KIND_PLAIN || gate)) return 8'hFF;
         if (on_clock()) begin
            if (wr) begin
               rtc_write(v);
               return 0;
            end
            clock_reads++;
            return rtc_read();
         end
         span = ram_span();
         if (span == 0) return 8'hFF;
         if (kind_eff() == KIND_MBC3 && sel > 3) return 8'hFF;
         bank = ram_bank & 4'hF;
         if (kind_eff() == KIND_MBC2 || (kind_eff() == KIND_MBC1 && mode == 0)) bank = 0;
         idx = (bank * 16'h2000 + a - 16'hA000) & (span - 1);
         if (kind_eff() == KIND_MBC2) begin
            if (wr) ram[idx] = 8'(v & 4'hF);
            return 8'hF0 | (ram[idx] & 4'hF);
         end
         if (wr) ram[idx] = 8'(v);
         return ram[idx];
      endfunction

      // Accepted request: advance the model and queue its bus result.
      function void note_request(logic [1:0] t, logic [15:0] a, logic [7:0] v);
         bus_result_type r;
         int unsigned off;
         r = '{8'h00, 1'b0, 23'h0};
         if (t == REQ_READ) begin
            if (a < 16'h8000) begin
               off = rom_bank(a) * 16'h4000 + (a & 16'h3FFF);
               if (off < rom_size && off < (1 << 23)) begin
                  r.fetch = 1;
                  r.addr = 23'(off);
               end else r.data = 8'hFF;
            end else if (a >= 16'hA000 && a < 16'hC000) r.data = 8'(window(a, 0, 0));
            else r.data = 8'hFF;
         end else if (t == REQ_WRITE) begin
            if (a < 16'h8000) bank_write(a, v);
            else if (a >= 16'hA000 && a < 16'hC000) void'(window(a, v, 1));
         end else if (t == REQ_TICK) rtc_advance();
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [7:0] data, logic fetch, logic [22:0] addr);
         bus_result_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result: read_data %0h rom_fetch %0b", data, fetch);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (fetch) fetches++;
         if (data !== e.data) begin
            $error("read_data: expected %0h, got %0h", e.data, data);
            errors++;
         end
         if (fetch !== e.fetch) begin
            $error("rom_fetch: expected %0b, got %0b", e.fetch, fetch);
            errors++;
         end
         if (addr !== e.addr) begin
            $error("rom_fetch_addr: expected %0h, got %0h", e.addr, addr);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic        rsp_tuser;
   logic [31:0] rsp_tdata;
   logic        csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   bank_scoreboard bus_model;
   int cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   cartridge_bank_controller_with_clock uut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("cartridge_bank_controller_with_clock_test: done, errors");
         $finish;
      end
   end

   always @(negedge clock) rsp_tready <= $urandom_range(99) >= stall_pct;

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         bus_model.check_result(rsp_tdata[7:0], rsp_tuser, rsp_tdata[30:8]);

   task automatic send_request(logic [1:0] t, logic [15:0] a, logic [7:0] v);
      req_tuser = t;
      req_tdata = {v, a};
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      bus_model.note_request(t, a, v);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   task automatic write_csr(logic [1:0] idx, int unsigned v);
      req_tvalid = 0;
      while (bus_model.expected_q.size() > 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = 24'(v);
      bus_model.set_reg(idx, v);
      @(negedge clock);
      csr_we = 0;
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] picks [12] = '{8'h0A, 8'h00, 8'h01, 8'h08, 8'h09, 8'h0A, 8'h0B,
                                 8'h0C, 8'd59, 8'd23, 8'hFF, 8'h40};
      if ($urandom_range(1)) return picks[$urandom_range(11)];
      return 8'($urandom_range(255));
   endfunction

   task automatic random_request(bit rtc_heavy);
      int r;
      logic [15:0] a;
      r = $urandom_range(99);
      if (r < (rtc_heavy ? 25 : 6)) send_request(REQ_TICK, 16'($urandom), 8'($urandom));
      else if (r < 40) begin
         a = 16'($urandom_range(3) * 16'h2000 + $urandom_range(16'h1FFF));
         send_request(REQ_WRITE, a, pick_byte());
      end else if (r < 65) begin
         a = 16'(16'hA000 + $urandom_range(16'h1FFF));
         send_request($urandom_range(1) ? REQ_WRITE : REQ_READ, a, pick_byte());
      end else if (r < 90) begin
         send_request(REQ_READ, 16'($urandom_range(16'h7FFF)), 8'($urandom));
      end else begin
         a = 16'($urandom_range(1) ? $urandom_range(16'h8000, 16'h9FFF)
                                   : $urandom_range(16'hC000, 16'hFFFF));
         r = $urandom_range(2);
         send_request(r == 2 ? REQ_NONE : 2'(r), a, 8'($urandom));
      end
   endtask

   // Seconds, minutes and day set to their top values, hour to 15, then ticked and latched.
   task automatic clock_directed();
      send_request(REQ_WRITE, 16'h0000, 8'h0A);
      send_request(REQ_WRITE, 16'h4000, CLK_SEC);
      send_request(REQ_WRITE, 16'hA000, 8'd59);
      send_request(REQ_WRITE, 16'h4000, CLK_MIN);
      send_request(REQ_WRITE, 16'hBFFF, 8'd119);
      send_request(REQ_WRITE, 16'h4000, CLK_HOUR);
      send_request(REQ_WRITE, 16'hA123, 8'hFF);
      send_request(REQ_WRITE, 16'h4000, CLK_DAYL);
      send_request(REQ_WRITE, 16'hA000, 8'hFF);
      send_request(REQ_WRITE, 16'h4000, CLK_DAYH);
      send_request(REQ_WRITE, 16'hA000, 8'h01);
      send_request(REQ_TICK, 16'h0000, 8'h00);
      send_request(REQ_WRITE, 16'h6000, 8'h00);
      send_request(REQ_WRITE, 16'h7FFF, 8'h01);
      send_request(REQ_READ, 16'hA000, 8'h00);
      send_request(REQ_WRITE, 16'h4000, CLK_SEC);
      send_request(REQ_READ, 16'hBFFF, 8'h00);
      send_request(REQ_WRITE, 16'h4000, 8'h05);
      send_request(REQ_READ, 16'hA000, 8'h00);
      send_request(REQ_WRITE, 16'h2000, 8'h00);
      send_request(REQ_READ, 16'h7FFF, 8'h00);
      send_request(REQ_READ, 16'h8000, 8'h00);
      send_request(REQ_NONE, 16'hFFFF, 8'hFF);
      send_request(REQ_WRITE, 16'h0000, 8'h00);
      send_request(REQ_READ, 16'hA000, 8'h00);
   endtask

   initial begin
      int unsigned cfg [PHASES][4] = '{
         '{KIND_MBC3, 1, 2097152, 32768},
         '{KIND_MBC1, 0, 2097152, 32768},
         '{KIND_MBC1, 1, 1048576, 8192},
         '{KIND_MBC2, 0, 262144, 512},
         '{KIND_MBC5, 0, 8388608, 131072},
         '{KIND_MBC3, 1, 0, 18'h3FFFF},
         '{3'd6, 1, 16'h3000, 3000},
         '{KIND_MBC3, 0, 24'hFFFFFF, 0},
         '{KIND_PLAIN, 0, 32768, 8192}};
      int stall_mode [4] = '{0, 0, 65, 16};
      int idle_mode [4] = '{0, 65, 0, 16};
      bus_model = new();
      bus_model.clear();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      for (int p = 0; p < PHASES; p++) begin
         for (int r = 0; r < 4; r++) write_csr(2'(r), cfg[p][r]);
         if (p == 0) clock_directed();
         for (int i = 0; i < 180; i++) begin
            idle_pct = idle_mode[(p + i / 45) % 4];
            stall_pct = stall_mode[(p + i / 45) % 4];
            random_request(cfg[p][0] == KIND_MBC3);
         end
      end
      req_tvalid = 0;
      stall_pct = 0;
      while (bus_model.expected_q.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("checked %0d bus results (%0d rom fetches, %0d clock register reads)",
               bus_model.checked, bus_model.fetches, bus_model.clock_reads);
      $display("over %0d controller settings with mixed source and sink stalls", PHASES);
      if (bus_model.errors == 0 && bus_model.expected_q.size() == 0)
         $display("cartridge_bank_controller_with_clock_test: done, clean");
      else
         $display("cartridge_bank_controller_with_clock_test: done, errors");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/cbc_pkg.sv
rtl/cbc_ram.sv
rtl/cartridge_bank_controller_with_clock.sv
tb/cartridge_bank_controller_with_clock_test.sv
